[src/lzw_pkg.sv]
// shared types, constants and tree sizing functions for the lzw encoder
package lzw_pkg;

  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 12;
  localparam int ENTRY_W    = CODE_W + BYTE_W;
  localparam int FIRST_FREE = 256;
  localparam int CODE_SPACE = 4096;
  localparam int FANIN      = 8;
  localparam int FANIN_SH   = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } lzw_state_e;

  // one dictionary entry as it moves down the chain
  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [CODE_W-1:0]  code;
  } lzw_slot_t;

  // insert request from the controller into the head of the chain
  typedef struct packed {
    logic      en;
    lzw_slot_t slot;
  } lzw_ins_t;

  // match report of one cell, zero when no match
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } lzw_leaf_t;

  // nodes on level lvl of a tree with n leaves
  function automatic int tree_nodes(input int n, input int lvl);
    int cnt;
    cnt = n;
    for (int l = 0; l < lvl; l++) begin
      cnt = (cnt + FANIN - 1) >> FANIN_SH;
    end
    return cnt;
  endfunction

  // registered levels above the leaves
  function automatic int tree_levels(input int n);
    int cnt;
    int lv;
    cnt = n;
    lv  = 0;
    while (cnt > 1) begin
      cnt = (cnt + FANIN - 1) >> FANIN_SH;
      lv  = lv + 1;
    end
    return (lv < 1) ? 1 : lv;
  endfunction

endpackage

[src/lzw_cell.sv]
// one dictionary cell: holds an entry, passes it on at insert, compares the key
module lzw_cell
  import lzw_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 12
) (
  input  logic               clk_i,
  input  logic               shift_i,
  input  lzw_slot_t          prev_i,
  output lzw_slot_t          slot_o,
  input  logic [ENTRY_W-1:0] key_i,
  input  logic [CW-1:0]      count_i,
  output lzw_leaf_t          leaf_o
);

  lzw_slot_t slot_q;
  lzw_leaf_t leaf_q;
  lzw_leaf_t leaf_d;

  always_comb begin
    leaf_d = '0;
    if ((count_i > CW'(IDX)) && (slot_q.entry == key_i)) begin
      leaf_d.hit  = 1'b1;
      leaf_d.code = slot_q.code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      slot_q <= prev_i;
    end
    leaf_q <= leaf_d;
  end

  assign slot_o = slot_q;
  assign leaf_o = leaf_q;

endmodule

[src/lzw_or_tree.sv]
// registered or-reduction tree that collects the single matching cell
module lzw_or_tree
  import lzw_pkg::*;
#(
  parameter int N = 3840
) (
  input  logic      clk_i,
  input  lzw_leaf_t leaf_i [N],
  output lzw_leaf_t root_o
);

  localparam int LEVELS = tree_levels(N);

  function automatic int level_off(input int lvl);
    int off;
    off = 0;
    for (int l = 1; l < lvl; l++) begin
      off = off + tree_nodes(N, l);
    end
    return off;
  endfunction

  localparam int TOTAL = level_off(LEVELS + 1);

  lzw_leaf_t node_q [TOTAL];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int NCUR  = tree_nodes(N, l);
    localparam int NPREV = tree_nodes(N, l - 1);
    localparam int OCUR  = level_off(l);
    localparam int OPREV = level_off(l - 1);
    for (genvar i = 0; i < NCUR; i++) begin : g_node
      lzw_leaf_t sum;
      if (l == 1) begin : g_first
        always_comb begin
          sum = '0;
          for (int k = 0; k < FANIN; k++) begin
            if (i * FANIN + k < NPREV) begin
              sum = sum | leaf_i[i * FANIN + k];
            end
          end
        end
      end else begin : g_upper
        always_comb begin
          sum = '0;
          for (int k = 0; k < FANIN; k++) begin
            if (i * FANIN + k < NPREV) begin
              sum = sum | node_q[OPREV + i * FANIN + k];
            end
          end
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[OCUR + i] <= sum;
      end
    end
  end

  assign root_o = node_q[TOTAL - 1];

endmodule

[src/lzw_encoder.sv]
// lzw encoder top level: controller, chain of dictionary cells and match tree
//
//   port group     | dir | handshake            | payload
//   ---------------+-----+----------------------+-------------------------------
//   input request  | in  | in_valid_i/in_stall_o | data_byte_i, end_of_chunk_i
//   output request | out | out_valid_o/out_stall_i | out_code_o, final_code_o
//
// the first byte of a chunk loads the prefix without a lookup; any other byte goes through the
// broadcast compare and the registered match tree, then through an emit state
// when a code is emitted (levels = 4 at the default size)
// reset empties the dictionary through the fill count, no clearing pass
// a stalled output holds the controller in its emit state; no input is taken then
module lzw_encoder
  import lzw_pkg::*;
#(
  parameter int DICT_SIZE = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              end_of_chunk_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CODE_W-1:0] out_code_o,
  output logic              final_code_o
);

  localparam int CODE_LIMIT = (DICT_SIZE > CODE_SPACE) ? CODE_SPACE : DICT_SIZE;
  localparam int NUM_CELLS  = CODE_LIMIT - FIRST_FREE;
  localparam int CW         = $clog2(NUM_CELLS + 1);
  localparam int LAT        = tree_levels(NUM_CELLS) + 1;
  localparam int TW         = $clog2(LAT + 1);

  lzw_state_e         state_q, state_d;
  logic [CODE_W-1:0]  prefix_q, prefix_d;
  logic               pvalid_q, pvalid_d;
  logic [CW-1:0]      count_q, count_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               last_q, last_d;
  logic [ENTRY_W-1:0] key_q, key_d;
  logic [TW-1:0]      wait_q, wait_d;
  logic               out_valid_q, out_valid_d;
  logic [CODE_W-1:0]  out_code_q, out_code_d;
  logic               out_final_q, out_final_d;
  logic               out_free;
  lzw_ins_t           ins;
  lzw_slot_t          chain [NUM_CELLS + 1];
  lzw_leaf_t          leaves [NUM_CELLS];
  lzw_leaf_t          root;

  assign chain[0] = ins.slot;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    lzw_cell #(
      .IDX (c),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (ins.en),
      .prev_i  (chain[c]),
      .slot_o  (chain[c + 1]),
      .key_i   (key_q),
      .count_i (count_q),
      .leaf_o  (leaves[c])
    );
  end

  lzw_or_tree #(
    .N (NUM_CELLS)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaves),
    .root_o (root)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d         = state_q;
    prefix_d        = prefix_q;
    pvalid_d        = pvalid_q;
    count_d         = count_q;
    byte_d          = byte_q;
    last_d          = last_q;
    key_d           = key_q;
    wait_d          = wait_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_code_d      = out_code_q;
    out_final_d     = out_final_q;
    ins.en          = 1'b0;
    ins.slot.entry  = key_q;
    ins.slot.code   = CODE_W'(count_q) + CODE_W'(FIRST_FREE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = data_byte_i;
          last_d = end_of_chunk_i;
          if (!pvalid_q) begin
            prefix_d = CODE_W'(data_byte_i);
            pvalid_d = 1'b1;
            if (end_of_chunk_i) begin
              state_d = ST_EMIT_LAST;
            end
          end else begin
            key_d   = {prefix_q, data_byte_i};
            wait_d  = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (wait_q == TW'(LAT)) begin
          if (root.hit) begin
            prefix_d = root.code;
            state_d  = last_q ? ST_EMIT_LAST : ST_IDLE;
          end else begin
            state_d = ST_EMIT_MISS;
          end
        end else begin
          wait_d = wait_q + TW'(1);
        end
      end
      ST_EMIT_MISS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_code_d  = prefix_q;
          out_final_d = 1'b0;
          if (count_q < CW'(NUM_CELLS)) begin
            ins.en  = 1'b1;
            count_d = count_q + CW'(1);
          end
          prefix_d = CODE_W'(byte_q);
          state_d  = last_q ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_code_d  = prefix_q;
          out_final_d = 1'b1;
          prefix_d    = '0;
          pvalid_d    = 1'b0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prefix_q    <= '0;
      pvalid_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      pvalid_q    <= pvalid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    last_q      <= last_d;
    key_q       <= key_d;
    wait_q      <= wait_d;
    out_code_q  <= out_code_d;
    out_final_q <= out_final_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_code_o   = out_code_q;
  assign final_code_o = out_final_q;

  // fill count never runs past the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NUM_CELLS))
    else $error("fill count beyond dictionary size");

  // a lookup only runs with a live prefix, and its wait never runs past LAT
  a_search_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> pvalid_q && wait_q <= TW'(LAT))
    else $error("lookup without prefix or wait overrun");

  // closing a chunk empties the dictionary and the prefix and flags the final code
  a_chunk_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_LAST && out_free) |=> !pvalid_q && count_q == '0 && out_final_q)
    else $error("chunk end did not clear state");

  // an insert grows the fill count by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins.en |=> count_q == $past(count_q) + CW'(1))
    else $error("insert without count step");

endmodule
